// ===== sv/lltk_pkg.sv =====
// Shared types and constants for the latitude/longitude tile key unit.
package lltk_pkg;

    localparam int unsigned LonW = 32;
    localparam int unsigned LatW = 31;
    localparam int unsigned DepthW = 5;
    localparam int unsigned IdxW = 23;
    localparam int unsigned StatW = 2;

    // Fraction bits of the fixed-point degree inputs; the ulp scaling is built for this width.
    localparam int unsigned CoordFracBits = 23;

    typedef enum logic [StatW-1:0] {
        ST_OK = 2'd0,
        ST_DEPTH = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    localparam logic [31:0] UlpLon = 32'hffff_ffff;
    localparam logic [30:0] UlpLat = 31'h7fff_ffff;

endpackage

// ===== sv/lltk_divider_stage.sv =====
// One restoring-division step: develops a single quotient bit.
module lltk_divider_stage #(
    parameter int unsigned NumW = 32
) (
    input  logic            i_clk,
    input  logic [NumW-1:0] i_rem,
    input  logic [NumW-1:0] i_num,
    input  logic [NumW-1:0] i_quo,
    input  logic [NumW-1:0] i_div,
    input  logic [5:0]      i_bit,
    output logic [NumW-1:0] o_rem,
    output logic [NumW-1:0] o_num,
    output logic [NumW-1:0] o_quo,
    output logic [NumW-1:0] o_div
);
    logic [NumW:0] n_trial;
    logic [NumW:0] n_sub;
    logic [NumW-1:0] r_rem, r_num, r_quo, r_div;

    always_comb begin
        n_trial = {i_rem, i_num[NumW-1]};
        n_sub = n_trial - {1'b0, i_div};
    end

    always_ff @(posedge i_clk) begin
        r_num <= {i_num[NumW-2:0], 1'b0};
        r_div <= i_div;
        if (!n_sub[NumW]) begin
            r_rem <= n_sub[NumW-1:0];
            r_quo <= i_quo | (NumW'(1) << i_bit);
        end else begin
            r_rem <= n_trial[NumW-1:0];
            r_quo <= i_quo;
        end
    end

    assign o_rem = r_rem;
    assign o_num = r_num;
    assign o_quo = r_quo;
    assign o_div = r_div;
endmodule

// ===== sv/lltk_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module lltk_divider #(
    parameter int unsigned NumW = 32
) (
    input  logic            i_clk,
    input  logic [NumW-1:0] i_num,
    input  logic [NumW-1:0] i_div,
    output logic [NumW-1:0] o_quo
);
    logic [NumW-1:0] w_rem [NumW+1];
    logic [NumW-1:0] w_num [NumW+1];
    logic [NumW-1:0] w_quo [NumW+1];
    logic [NumW-1:0] w_div [NumW+1];

    assign w_rem[0] = '0;
    assign w_num[0] = i_num;
    assign w_quo[0] = '0;
    assign w_div[0] = i_div;

    for (genvar g = 0; g < NumW; g++) begin : g_stage
        lltk_divider_stage #(.NumW(NumW)) u_stage (
            .i_clk(i_clk),
            .i_rem(w_rem[g]), .i_num(w_num[g]), .i_quo(w_quo[g]), .i_div(w_div[g]),
            .i_bit(6'(NumW - 1 - g)),
            .o_rem(w_rem[g+1]), .o_num(w_num[g+1]), .o_quo(w_quo[g+1]),
            .o_div(w_div[g+1])
        );
    end

    assign o_quo = w_quo[NumW];
endmodule

// ===== sv/latlon_to_tile_key_unit.sv =====
// Top level: maps longitude, latitude and depth to a tile column and row.
//
//  channel  | handshake               | beat
//  ---------+-------------------------+------------------------------------
//  command  | i_start, o_busy         | i_longitude, i_latitude, i_depth
//  result   | o_done strobe           | o_tile_col, o_tile_row, o_status
//
// One beat enters per cycle; o_busy is always low. The path holds 38 register stages:
// one stage of offset and range check, four stages of ulp scaling (reciprocal multiply,
// remainder, fold, and correction with step setup), 32 stages of the pipelined index
// divider, one clamp.
// Synchronous active-low reset clears the valid pipeline; data needs none.
// The receiver cannot stall, so no back-pressure exists inside.
module latlon_to_tile_key_unit #(
    parameter int unsigned DEPTH_LIMIT = 23
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic signed [31:0]    i_longitude,
    input  logic signed [30:0]    i_latitude,
    input  logic [4:0]            i_depth,
    output logic                  o_done,
    output logic [22:0]           o_tile_col,
    output logic [22:0]           o_tile_row,
    output logic [1:0]            o_status
);
    import lltk_pkg::*;

    localparam logic [63:0] LonSpan = 64'(360) << CoordFracBits;
    localparam logic [63:0] LatSpan = 64'(180) << CoordFracBits;
    localparam logic [63:0] LonHalf = 64'(180) << CoordFracBits;
    localparam logic [63:0] LatHalf = 64'(90) << CoordFracBits;
    localparam int unsigned DivIdx = 32;
    // floor(n * Recip45 / 2^38) is floor(n / 45) for every 32-bit n.
    localparam logic [32:0] Recip45 = 33'd6108397933;
    // floor(r * Recip45Small / 2^12) is floor(64 * r / 45) for r up to 44.
    localparam logic [12:0] Recip45Small = 13'd5826;

    // Stage 1: offset and range check.
    logic        r_s1_v;
    logic [31:0] r_s1_lon;
    logic [31:0] r_s1_lat;
    logic [4:0]  r_s1_d;
    t_status     r_s1_st;
    logic signed [33:0] n_lon;
    logic signed [32:0] n_lat;
    t_status     n_st;

    always_comb begin
        n_lon = 34'(i_longitude) + 34'(signed'({1'b0, LonHalf[32:0]}));
        n_lat = 33'(i_latitude) + 33'(signed'({1'b0, LatHalf[31:0]}));
        if (32'(i_depth) > DEPTH_LIMIT) begin
            n_st = ST_DEPTH;
        end else if (n_lon < 0 || 64'(n_lon) > LonSpan || n_lat < 0 ||
                     64'(n_lat) > LatSpan) begin
            n_st = ST_RANGE;
        end else begin
            n_st = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s1_v <= 1'b0;
        else r_s1_v <= i_start;
        r_s1_lon <= n_lon[31:0];
        r_s1_lat <= n_lat[31:0];
        r_s1_d <= i_depth;
        r_s1_st <= n_st;
    end

    // Both spans are 45 times a power of two, so an offset L scales to
    // floor(64*L/45 - L/span) ulps. Stage 2 takes floor(L/45).
    logic        r_s2_v;
    logic [26:0] r_s2_lonq, r_s2_latq;
    logic [31:0] r_s2_lon, r_s2_lat;
    logic [4:0]  r_s2_d;
    t_status     r_s2_st;
    logic [64:0] n_lonp, n_latp;
    always_comb begin
        n_lonp = 65'(r_s1_lon) * 65'(Recip45);
        n_latp = 65'(r_s1_lat) * 65'(Recip45);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s2_v <= 1'b0;
        else r_s2_v <= r_s1_v;
        r_s2_lonq <= n_lonp[64:38];
        r_s2_latq <= n_latp[64:38];
        r_s2_lon <= r_s1_lon;
        r_s2_lat <= r_s1_lat;
        r_s2_d <= r_s1_d;
        r_s2_st <= r_s1_st;
    end

    // Stage 3: remainder of the divide by 45.
    logic        r_s3_v;
    logic [26:0] r_s3_lonq, r_s3_latq;
    logic [5:0]  r_s3_lonr, r_s3_latr;
    logic [31:0] r_s3_lon, r_s3_lat;
    logic [4:0]  r_s3_d;
    t_status     r_s3_st;
    logic [31:0] n_lonm, n_latm;
    always_comb begin
        n_lonm = 32'(r_s2_lonq) * 32'd45;
        n_latm = 32'(r_s2_latq) * 32'd45;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s3_v <= 1'b0;
        else r_s3_v <= r_s2_v;
        r_s3_lonq <= r_s2_lonq;
        r_s3_latq <= r_s2_latq;
        r_s3_lonr <= 6'(r_s2_lon - n_lonm);
        r_s3_latr <= 6'(r_s2_lat - n_latm);
        r_s3_lon <= r_s2_lon;
        r_s3_lat <= r_s2_lat;
        r_s3_d <= r_s2_d;
        r_s3_st <= r_s2_st;
    end

    // Stage 4: fold 64 times the remainder into six low quotient bits and a new remainder.
    logic        r_s4_v;
    logic [26:0] r_s4_lonq, r_s4_latq;
    logic [5:0]  r_s4_lonc, r_s4_latc;
    logic [5:0]  r_s4_lone, r_s4_late;
    logic [31:0] r_s4_lon, r_s4_lat;
    logic [4:0]  r_s4_d;
    t_status     r_s4_st;
    logic [17:0] n_lonf, n_latf;
    always_comb begin
        n_lonf = 18'(r_s3_lonr) * 18'(Recip45Small);
        n_latf = 18'(r_s3_latr) * 18'(Recip45Small);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s4_v <= 1'b0;
        else r_s4_v <= r_s3_v;
        r_s4_lonq <= r_s3_lonq;
        r_s4_latq <= r_s3_latq;
        r_s4_lonc <= n_lonf[17:12];
        r_s4_latc <= n_latf[17:12];
        r_s4_lone <= 6'({r_s3_lonr, 6'b0} - 12'(n_lonf[17:12]) * 12'd45);
        r_s4_late <= 6'({r_s3_latr, 6'b0} - 12'(n_latf[17:12]) * 12'd45);
        r_s4_lon <= r_s3_lon;
        r_s4_lat <= r_s3_lat;
        r_s4_d <= r_s3_d;
        r_s4_st <= r_s3_st;
    end

    // Stage 5: drop one ulp when the remainder falls short of the sub-unit term,
    // and set up the depth's step.
    logic        r_s5_v;
    logic [4:0]  r_s5_d;
    t_status     r_s5_st;
    logic [31:0] r_xs, r_ys, r_sx, r_sy;
    logic [32:0] n_x, n_y;
    logic [31:0] n_sx, n_sy;
    always_comb begin
        n_x = {r_s4_lonq, r_s4_lonc} - 33'({r_s4_lone, 26'b0} < r_s4_lon);
        n_y = {r_s4_latq, r_s4_latc} - 33'({1'b0, r_s4_late, 25'b0} < r_s4_lat);
        n_sx = UlpLon >> r_s4_d;
        n_sy = 32'(UlpLat >> r_s4_d);
        if (n_sx == '0) n_sx = 32'd1;
        if (n_sy == '0) n_sy = 32'd1;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s5_v <= 1'b0;
        else r_s5_v <= r_s4_v;
        r_s5_d <= r_s4_d;
        r_s5_st <= r_s4_st;
        r_xs <= n_x[31:0];
        r_ys <= n_y[31:0];
        r_sx <= n_sx;
        r_sy <= n_sy;
    end

    logic [31:0] w_cq, w_rq;
    lltk_divider #(.NumW(32)) u_divc (.i_clk(i_clk), .i_num(r_xs), .i_div(r_sx),
        .o_quo(w_cq));
    lltk_divider #(.NumW(32)) u_divr (.i_clk(i_clk), .i_num(r_ys), .i_div(r_sy),
        .o_quo(w_rq));

    // Side pipeline carrying valid, depth and status alongside the index dividers.
    logic        r_v [DivIdx];
    logic [4:0]  r_d [DivIdx];
    t_status     r_st [DivIdx];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DivIdx; i++) r_v[i] <= 1'b0;
        end else begin
            r_v[0] <= r_s5_v;
            for (int i = 1; i < DivIdx; i++) r_v[i] <= r_v[i-1];
        end
        r_d[0] <= r_s5_d;
        r_st[0] <= r_s5_st;
        for (int i = 1; i < DivIdx; i++) begin
            r_d[i] <= r_d[i-1];
            r_st[i] <= r_st[i-1];
        end
    end

    // Clamp and output register.
    localparam int unsigned OIx = DivIdx - 1;
    logic [31:0] n_top;
    logic        r_done;
    logic [22:0] r_col, r_row;
    t_status     r_stat;
    always_comb n_top = (32'd1 << r_d[OIx]) - 32'd1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done <= 1'b0;
        else r_done <= r_v[OIx];
        r_stat <= r_st[OIx];
        if (r_st[OIx] != ST_OK) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= (w_cq > n_top) ? n_top[22:0] : w_cq[22:0];
            r_row <= (w_rq > n_top) ? n_top[22:0] : w_rq[22:0];
        end
    end

    assign o_busy = 1'b0;
    assign o_done = r_done;
    assign o_tile_col = r_col;
    assign o_tile_row = r_row;
    assign o_status = r_stat;

`ifndef SYNTHESIS
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status != 2'd3)) else $error("bad status");
    a_zero_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> (o_tile_col == '0 && o_tile_row == '0))
        else $error("nonzero index on error");
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[OIx] |=> o_done) else $error("lost beat");
`endif
endmodule
